@@ rtl/dtfp_pkg.sv @@
// Shared types and constants for the decimal text to fixed point converter.
// No dependencies; every other file imports this package.
package dtfp_pkg;

	localparam int unsigned MAX_CHARS = 7;

	localparam logic [15:0] ERROR_VALUE   = 16'd65535;
	localparam logic [16:0] LARGEST_VALUE = 17'd65534;
	localparam logic [7:0]  CODE_ZERO     = 8'd48;
	localparam logic [7:0]  CODE_NINE     = 8'd57;
	localparam logic [7:0]  CODE_POINT    = 8'd46;
	localparam logic [7:0]  CODE_FIVE     = 8'd53;

	localparam logic [3:0]  CHAR_LIMIT    = 4'(MAX_CHARS);
	localparam logic [2:0]  INT_DIG_SAT   = 3'd4;
	localparam logic [2:0]  INT_DIG_MAX   = 3'd3;
	localparam logic [1:0]  FRAC_DIG_TWO  = 2'd2;
	localparam logic [1:0]  FRAC_DIG_DONE = 2'd3;

	// Parse state carried from one character to the next
	typedef struct packed {
		logic [16:0] acc;
		logic [2:0]  int_dig;
		logic [1:0]  frac_dig;
		logic        point;
		logic        digit;
		logic        bad;
		logic        round;
		logic [3:0]  cnt;
	} parse_st_t;

endpackage

@@ rtl/decimal_text_to_fixed_point_top.sv @@
// Decimal text to fixed point converter, top level.
// The last character goes through the input register, the final state snapshot and the output register to a result.
// Throughput: one character per cycle; each stage stalls only on its own successor.
// The parse step is one shift-add multiply by ten; result scaling has its own stage.
// Reset (arst_n low, asynchronous) clears parse state and all valid flags.
// Depends on dtfp_pkg, dtfp_step, dtfp_result.
module decimal_text_to_fixed_point_top
	import dtfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] value,
	output logic        error
);

	logic        v_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	parse_st_t   st_q;
	parse_st_t   st_nxt;
	logic        v_s2;
	parse_st_t   fin_s2;
	logic [15:0] res_value;
	logic        res_error;
	logic [15:0] value_q;
	logic        error_q;
	logic        out_valid_q;

	logic out_en;
	logic s2_free;
	logic s1_go;

	// stage enables
	assign out_en   = !out_valid_q || out_ready;
	assign s2_free  = !v_s2 || out_en;
	assign s1_go    = v_s1 && (!last_s1 || s2_free);
	assign in_ready = !v_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	dtfp_step u_step (
		.cur       (st_q),
		.char_code (char_s1),
		.nxt       (st_nxt)
	);

	// parse state; cleared after the last character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (s1_go) begin
			st_q <= last_s1 ? '0 : st_nxt;
		end
	end

	// final state snapshot for the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			fin_s2 <= st_nxt;
		end
	end

	dtfp_result u_result (
		.fin   (fin_s2),
		.value (res_value),
		.error (res_error)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && v_s2) begin
			value_q <= res_value;
			error_q <= res_error;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign error     = error_q;

endmodule

@@ rtl/dtfp_step.sv @@
// Per-character parse update: folds one character into the parse state.
// Depends on dtfp_pkg.
module dtfp_step
	import dtfp_pkg::*;
(
	input  parse_st_t  cur,
	input  logic [7:0] char_code,
	output parse_st_t  nxt
);

	logic        is_digit;
	logic [16:0] digit_ext;
	logic [16:0] acc_mac;
	logic [2:0]  int_inc;

	assign is_digit  = (char_code >= CODE_ZERO) && (char_code <= CODE_NINE);
	assign digit_ext = {9'd0, char_code - CODE_ZERO};
	// acc * 10 + d, as shift-add, kept to 17 bits
	assign acc_mac   = (cur.acc << 3) + (cur.acc << 1) + digit_ext;
	assign int_inc   = (cur.int_dig < INT_DIG_SAT) ? cur.int_dig + 3'd1 : cur.int_dig;

	always_comb begin
		nxt = cur;

		// length check
		if (cur.cnt >= CHAR_LIMIT) begin
			nxt.bad = 1'b1;
		end else begin
			nxt.cnt = cur.cnt + 4'd1;
		end

		// character class
		if (is_digit) begin
			nxt.digit = 1'b1;
			if (!cur.point) begin
				nxt.int_dig = int_inc;
				if (int_inc <= INT_DIG_MAX) begin
					nxt.acc = acc_mac;
				end
			end else if (cur.frac_dig < FRAC_DIG_TWO) begin
				nxt.frac_dig = cur.frac_dig + 2'd1;
				nxt.acc      = acc_mac;
			end else if (cur.frac_dig == FRAC_DIG_TWO) begin
				nxt.frac_dig = FRAC_DIG_DONE;
				nxt.round    = (char_code >= CODE_FIVE);
			end
		end else if ((char_code == CODE_POINT) && !cur.point) begin
			nxt.point = 1'b1;
		end else begin
			nxt.bad = 1'b1;
		end
	end

endmodule

@@ rtl/dtfp_result.sv @@
// Result formation: scales the final parse state to hundredths and flags bad text or out-of-range values.
// Depends on dtfp_pkg.
module dtfp_result
	import dtfp_pkg::*;
(
	input  parse_st_t   fin,
	output logic [15:0] value,
	output logic        error
);

	logic [16:0] scaled;
	logic [16:0] total;

	// scale to hundredths by the number of decimals taken
	always_comb begin
		case (fin.frac_dig)
			2'd0:    scaled = (fin.acc << 6) + (fin.acc << 5) + (fin.acc << 2);
			2'd1:    scaled = (fin.acc << 3) + (fin.acc << 1);
			default: scaled = fin.acc;
		endcase
	end

	assign total = scaled + {16'd0, fin.round};

	assign error = fin.bad || !fin.digit || (fin.int_dig > INT_DIG_MAX) ||
		(total > LARGEST_VALUE);
	assign value = error ? ERROR_VALUE : total[15:0];

endmodule

@@ tb/decimal_text_to_fixed_point_top_tb.sv @@
// Self-checking testbench for decimal_text_to_fixed_point_top: feeds number text one
// character per request and checks each hundredths result against a built-in predictor.
// Depends on dtfp_pkg and the RTL of decimal_text_to_fixed_point_top.
module decimal_text_to_fixed_point_top_tb
	import dtfp_pkg::*;
;

	localparam int RANDOM_CHARS   = 1400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 10;

	// One expected conversion result
	typedef struct {
		logic [15:0] value;
		logic        error;
	} conversion_t;

	// Tracks parse state per accepted character and holds results still owed
	class hundredths_scoreboard;
		parse_st_t   st;
		conversion_t pending_conversions[$];
		int          mismatches;
		int          strings;
		int          error_results;

		function new();
			st = '0;
			mismatches = 0;
			strings = 0;
			error_results = 0;
		endfunction

		function void note_char(logic [7:0] c, logic is_last);
			logic [31:0] total;
			logic        err;
			conversion_t res;
			// length limit: the count saturates, overrun marks the text bad
			if (st.cnt >= CHAR_LIMIT)
				st.bad = 1'b1;
			else
				st.cnt = st.cnt + 4'd1;
			if (c >= CODE_ZERO && c <= CODE_NINE) begin
				st.digit = 1'b1;
				if (!st.point) begin
					if (st.int_dig < INT_DIG_SAT)
						st.int_dig = st.int_dig + 3'd1;
					if (st.int_dig <= INT_DIG_MAX)
						st.acc = 17'(32'(st.acc) * 10 + 32'(c - CODE_ZERO));
				end else if (st.frac_dig < FRAC_DIG_TWO) begin
					st.frac_dig = st.frac_dig + 2'd1;
					st.acc = 17'(32'(st.acc) * 10 + 32'(c - CODE_ZERO));
				end else if (st.frac_dig == FRAC_DIG_TWO) begin
					// third decimal only decides rounding
					st.frac_dig = FRAC_DIG_DONE;
					st.round = (c >= CODE_FIVE);
				end
			end else if (c == CODE_POINT && !st.point) begin
				st.point = 1'b1;
			end else begin
				st.bad = 1'b1;
			end
			if (!is_last)
				return;

			// scale to hundredths and judge the whole string
			total = 32'(st.acc);
			if (st.frac_dig == 2'd0)
				total = total * 100;
			else if (st.frac_dig == 2'd1)
				total = total * 10;
			total = total + 32'(st.round);
			err = st.bad || !st.digit || st.int_dig > INT_DIG_MAX ||
				total > 32'(LARGEST_VALUE);
			res.value = err ? ERROR_VALUE : total[15:0];
			res.error = err;
			pending_conversions.push_back(res);
			strings++;
			if (err)
				error_results++;
			st = '0;
		endfunction

		function void check_result(logic [15:0] got_value, logic got_error);
			conversion_t exp_res;
			if (pending_conversions.size() == 0) begin
				$error("unexpected result: value %0d error %0b", got_value, got_error);
				mismatches++;
				return;
			end
			exp_res = pending_conversions.pop_front();
			if (got_value !== exp_res.value) begin
				$error("value: expected %0d, got %0d", exp_res.value, got_value);
				mismatches++;
			end
			if (got_error !== exp_res.error) begin
				$error("error: expected %0b, got %0b", exp_res.error, got_error);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_conversions.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        last_char;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] value;
	logic        error;

	hundredths_scoreboard sb = new();
	logic [7:0] text[$];
	logic       steady;
	int         chars_sent;
	int         idle_cycles;

	decimal_text_to_fixed_point_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_code(char_code),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value),
		.error    (error)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap length: mostly none, some short, a few long; none in steady stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(CODE_ZERO + $urandom_range(0, 9));
	endfunction

	// Well-formed number text, sometimes close to the largest value
	function automatic void build_well_formed();
		int   r;
		int   nint;
		int   nfrac;
		logic near;
		text.delete();
		r = $urandom_range(0, 99);
		nint = (r < 10) ? 0 : (r < 88) ? $urandom_range(1, 3) : $urandom_range(4, 5);
		near = (nint == 3) && ($urandom_range(0, 3) == 0);
		for (int i = 0; i < nint; i++) begin
			if (near && i == 0)
				text.push_back("6");
			else if (near && i == 1)
				text.push_back("5");
			else if (near)
				text.push_back(8'(CODE_ZERO + $urandom_range(4, 5)));
			else
				text.push_back(rand_digit());
		end
		if (nint == 0 || $urandom_range(0, 3) != 0) begin
			text.push_back(CODE_POINT);
			nfrac = $urandom_range((nint == 0) ? 1 : 0, 5);
			for (int i = 0; i < nfrac; i++)
				text.push_back(rand_digit());
		end
	endfunction

	// Mostly valid text, some with one corrupted spot, some pure noise
	function automatic void build_random_text();
		int r;
		int pos;
		int len;
		int pick;
		r = $urandom_range(0, 99);
		if (r < 92) begin
			build_well_formed();
			if (r >= 80) begin
				pos = $urandom_range(0, text.size() - 1);
				if ($urandom_range(0, 1))
					text[pos] = 8'($urandom_range(0, 255));
				else
					text.insert(pos, CODE_POINT);
			end
		end else begin
			text.delete();
			len = $urandom_range(1, 10);
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					text.push_back(rand_digit());
				else if (pick < 60)
					text.push_back(CODE_POINT);
				else
					text.push_back(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	function automatic void load_text(string s);
		text.delete();
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endfunction

	// Present one character and hold it until the request is taken
	task automatic send_char(logic [7:0] c, logic is_last);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		char_code = c;
		last_char = is_last;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_char(c, is_last);
		chars_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++)
			send_char(text[i], i == text.size() - 1);
	endtask

	// Stop sending until every owed result has come back
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls on out_ready
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// Check every result taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(value, error);
	end

	// Watchdog: ends the run when nothing moves for too long
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Main stimulus
	initial begin
		int nstr;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = 8'd0;
		last_char = 1'b0;
		steady = 1'b0;
		chars_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: overflow after rounding, lone point, leading zeros too many,
		// NUL and top byte, second point, extra decimals with round up, overlong text
		load_text("655.345");
		send_text();
		load_text(".");
		send_text();
		load_text("0123");
		send_text();
		text = {8'h00};
		send_text();
		text = {8'hFF};
		send_text();
		load_text("..");
		send_text();
		load_text("9.1256");
		send_text();
		load_text("00000000");
		send_text();
		hold_until_drained();

		// random strings, with steady stretches and occasional full drains
		nstr = 0;
		while (chars_sent < RANDOM_CHARS) begin
			if (nstr % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			build_random_text();
			send_text();
			nstr++;
			if (nstr % 70 == 0)
				hold_until_drained();
		end
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.mismatches++;
		end
		$display("Sent %0d characters in %0d strings; %0d results were error values.",
			chars_sent, sb.strings, sb.error_results);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
